@@ hw/rtl/sorted_deadline_timer_queue_defines.svh @@
// assertion macros for the sorted deadline timer queue
// used by the datapath module; no other dependencies
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDTQ_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sdtq assertion failed");

// next-cycle implication, checked outside reset
`define SDTQ_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sdtq assertion failed");

`endif

@@ hw/rtl/sdtq_pkg.sv @@
// shared constants, codes and control structs of the sorted deadline timer queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdtq_pkg;

    localparam int DEPTH    = 16;
    localparam int OCC_W    = $clog2(DEPTH + 1);
    localparam int ID_W     = 10;
    localparam int TIME_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADJUST = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd3;

    typedef struct packed {
        logic load_req;
        logic search;
        logic remove;
        logic insert;
        logic pop;
        logic emit_status;
        logic emit_expire;
    } sdtq_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             hit;
        logic             full;
        logic             head_exp;
        logic             next_exp;
        logic             out_free;
    } sdtq_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/sdtq_datapath.sv @@
// datapath: request registers, sorted slot row, occupancy and output register
// depends on sdtq_pkg and sorted_deadline_timer_queue_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_deadline_timer_queue_defines.svh"

module sdtq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [sdtq_pkg::REQ_W-1:0]    req_type,
    input  wire logic [sdtq_pkg::ID_W-1:0]     timer_id,
    input  wire logic [sdtq_pkg::TIME_W-1:0]   deadline,
    input  wire logic [sdtq_pkg::TIME_W-1:0]   now_time,
    input  wire logic                          out_stall,
    input  wire sdtq_pkg::sdtq_cmd_t           cmd,
    output sdtq_pkg::sdtq_stat_t               stat,
    output logic                               out_valid,
    output logic [sdtq_pkg::ID_W-1:0]          expired_id,
    output logic                               fired,
    output logic [sdtq_pkg::STATUS_W-1:0]      status,
    output logic                               last
);
    import sdtq_pkg::*;

    logic [REQ_W-1:0]  req_type_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] dl_reg;
    logic [TIME_W-1:0] now_reg;

    logic [ID_W-1:0]   slot_id_reg   [DEPTH];
    logic [TIME_W-1:0] slot_dl_reg   [DEPTH];
    logic [ID_W-1:0]   slot_id_next  [DEPTH];
    logic [TIME_W-1:0] slot_dl_next  [DEPTH];
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    logic [DEPTH-1:0]  hit_reg;
    logic              full_reg;
    logic [DEPTH-1:0]  hit_vec;
    logic [DEPTH-1:0]  le_vec;
    logic [DEPTH-1:0]  rm_mask;
    logic [DEPTH-1:0]  shift_en;

    logic                out_valid_reg;
    logic [ID_W-1:0]     expired_id_reg;
    logic                fired_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;
    logic [STATUS_W-1:0] req_status;
    logic                out_free;

    localparam int NextIdx = (DEPTH > 1) ? 1 : 0;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            id_reg       <= timer_id;
            dl_reg       <= deadline;
            now_reg      <= now_time;
        end
    end

    // per-slot compares against the latched request
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_vec[i] = (occ_reg > OCC_W'(i)) && (slot_id_reg[i] == id_reg);
            le_vec[i]  = (occ_reg > OCC_W'(i)) && (slot_dl_reg[i] <= dl_reg);
        end
    end

    // ids are unique, so the hit is one-hot: mask covers the hit slot and above
    assign rm_mask  = ~(hit_reg - DEPTH'(1));
    assign shift_en = ({DEPTH{cmd.remove}} & rm_mask) | {DEPTH{cmd.pop}};

    genvar g;
    for (g = 0; g < DEPTH; g++)
    begin : g_slot
        localparam int Up = (g < DEPTH - 1) ? g + 1 : g;
        localparam int Dn = (g > 0) ? g - 1 : 0;
        logic new_here;

        // le_vec is a prefix, so the new word lands at the first slot past it
        assign new_here = (g == 0) || le_vec[Dn];

        always_comb
        begin
            slot_id_next[g] = slot_id_reg[g];
            slot_dl_next[g] = slot_dl_reg[g];
            if (shift_en[g])
            begin
                slot_id_next[g] = slot_id_reg[Up];
                slot_dl_next[g] = slot_dl_reg[Up];
            end
            else if (cmd.insert && !le_vec[g])
            begin
                if (new_here)
                begin
                    slot_id_next[g] = id_reg;
                    slot_dl_next[g] = dl_reg;
                end
                else
                begin
                    slot_id_next[g] = slot_id_reg[Dn];
                    slot_dl_next[g] = slot_dl_reg[Dn];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_id_reg[i] <= slot_id_next[i];
            slot_dl_reg[i] <= slot_dl_next[i];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.remove || cmd.pop)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
        else if (cmd.insert)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            hit_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cmd.search)
            begin
                hit_reg  <= hit_vec;
                full_reg <= (occ_reg == OCC_W'(DEPTH));
            end
        end
    end

    always_comb
    begin
        case (req_type_reg)
            REQ_ADD:
            begin
                if (|hit_reg)
                    req_status = ST_PRESENT;
                else if (full_reg)
                    req_status = ST_FULL;
                else
                    req_status = ST_OK;
            end
            REQ_ADJUST, REQ_DELETE:
            begin
                req_status = (|hit_reg) ? ST_OK : ST_ABSENT;
            end
            default:
            begin
                req_status = ST_OK;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_status || cmd.emit_expire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_expire)
        begin
            expired_id_reg <= slot_id_reg[0];
            fired_reg      <= 1'b1;
            status_reg     <= ST_OK;
            last_reg       <= !stat.next_exp;
        end
        else if (cmd.emit_status)
        begin
            expired_id_reg <= '0;
            fired_reg      <= 1'b0;
            status_reg     <= req_status;
            last_reg       <= 1'b1;
        end
    end

    assign stat.req_type = req_type_reg;
    assign stat.hit      = |hit_reg;
    assign stat.full     = full_reg;
    assign stat.head_exp = (occ_reg != '0) && (slot_dl_reg[0] <= now_reg);
    assign stat.next_exp = (occ_reg > OCC_W'(1)) && (slot_dl_reg[NextIdx] <= now_reg);
    assign stat.out_free = out_free;

    assign out_valid  = out_valid_reg;
    assign expired_id = expired_id_reg;
    assign fired      = fired_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    `SDTQ_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(DEPTH))
    `SDTQ_ASSERT_NOW(a_unique_ids, clk, rst_n, 1'b1, $onehot0(hit_reg))
    `SDTQ_ASSERT_NOW(a_insert_room, clk, rst_n, cmd.insert, occ_reg < OCC_W'(DEPTH))
    `SDTQ_ASSERT_NEXT(a_pop_count, clk, rst_n, cmd.pop,
        occ_reg == $past(occ_reg) - OCC_W'(1))

endmodule

`default_nettype wire

@@ hw/rtl/sdtq_ctrl.sv @@
// controller state machine: sequences search, remove, insert and expiry
// depends on sdtq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdtq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire sdtq_pkg::sdtq_stat_t stat,
    output sdtq_pkg::sdtq_cmd_t  cmd
);
    import sdtq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_REMOVE = 6'b000100,
        S_INSERT = 6'b001000,
        S_DONE   = 6'b010000,
        S_EXPIRE = 6'b100000
    } sdtq_state_t;

    sdtq_state_t state_reg;
    sdtq_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = (stat.req_type == REQ_TICK) ? S_EXPIRE : S_REMOVE;
            end
            S_REMOVE:
            begin
                cmd.remove = (stat.req_type != REQ_ADD) && stat.hit;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = ((stat.req_type == REQ_ADD) && !stat.hit && !stat.full)
                          || ((stat.req_type == REQ_ADJUST) && stat.hit);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EXPIRE:
            begin
                // last is known ahead, so a non-expired head only shows on the first pass
                if (stat.out_free)
                begin
                    if (stat.head_exp)
                    begin
                        cmd.emit_expire = 1'b1;
                        cmd.pop         = 1'b1;
                        if (!stat.next_exp)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_status = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/sorted_deadline_timer_queue.sv @@
// top level of the sorted deadline timer queue: controller plus datapath
// depends on sdtq_pkg, sdtq_ctrl and sdtq_datapath
//
//   channel  | handshake          | word
//   ---------+--------------------+------------------------------------------
//   in       | in_valid, in_stall | req_type, timer_id, deadline, now_time
//   out      | out_valid, out_stall | expired_id, fired, status, last
//
// add, adjust, delete: result word registered after the search, remove, insert
//   and report steps of the controller; report waits for a free output
// tick: first result registered in the expiry step, then one word per cycle
//   per expired timer while not stalled, one head pop per cycle from the slot row
// a stalled output holds the word and pauses the sequence; reset empties the queue
`timescale 1ns / 1ps
`default_nettype none

module sorted_deadline_timer_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sdtq_pkg::REQ_W-1:0]    req_type,
    input  wire logic [sdtq_pkg::ID_W-1:0]     timer_id,
    input  wire logic [sdtq_pkg::TIME_W-1:0]   deadline,
    input  wire logic [sdtq_pkg::TIME_W-1:0]   now_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sdtq_pkg::ID_W-1:0]          expired_id,
    output logic                               fired,
    output logic [sdtq_pkg::STATUS_W-1:0]      status,
    output logic                               last
);
    import sdtq_pkg::*;

    sdtq_cmd_t  cmd;
    sdtq_stat_t stat;

    sdtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdtq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .timer_id   (timer_id),
        .deadline   (deadline),
        .now_time   (now_time),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .expired_id (expired_id),
        .fired      (fired),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire
